### rtl/core/ptre_pkg.sv
// shared types and constants of the periodic task release engine
`timescale 1ns / 1ps
`default_nettype none

package ptre_pkg;

   // request action codes
   typedef enum logic [1:0] {
      ACT_REGISTER = 2'd0,
      ACT_POLL     = 2'd1,
      ACT_REPORT   = 2'd2,
      ACT_QUERY    = 2'd3
   } ptre_action_type;

   // operation of the shared adder
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } ptre_alu_op_type;

   // adder outputs seen by the sequencer
   typedef struct packed {
      logic [31:0] value;
      logic        borrow;
      logic        zero;
      logic        sign;
   } ptre_alu_res_type;

   // one row of the task table
   typedef struct packed {
      logic [31:0] period;
      logic [31:0] due;
      logic [31:0] worst;
      logic [31:0] acts;
   } ptre_entry_type;

   // at most this many releases per poll
   localparam int unsigned RESULTS_LIMIT = 16;
   localparam int unsigned HITS_W        = 5;
   localparam int unsigned IDX_W         = 4;
   localparam int unsigned COUNT_OUT_W   = 5;
   localparam logic [31:0] LIMIT_RESET   = 32'd10;

endpackage

`default_nettype wire

### rtl/core/periodic_task_release_engine_core.sv
// top level of the periodic task release engine: sequencer, task table, shared adder
//  - req channel: one request per handshake (valid high, stall low); action selects
//    register task, poll at time, report duration or query statistics
//  - rsp channel: one or more results per request; last_result marks the final one.
//    a poll gives one result per released task in slot order (at most sixteen), or
//    a single result with released clear when nothing is due
//  - csr port: write enable and data for the overrun limit (reset value 10);
//    write it only while the block is idle
//  - work per request is set by one shared 32-bit adder and a task ram with one
//    write and one read port: a report takes an extra step when an overrun counts,
//    a poll's work grows with each task not due and each released task, and
//    receiver stalls add to it
//  - req_stall is high from acceptance until the last result is loaded into the
//    output register, so one request is in flight at a time
//  - when the receiver stalls, the result holds in the output register and the
//    sequencer waits before loading the next one; no result is dropped
//  - synchronous reset empties the table (task count zero), clears the overrun
//    counter, drops any pending result and restores the overrun limit; the table
//    ram needs no clearing since slots are written before they are ever read
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_release_engine_core #(
   parameter int unsigned MAX_TASKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [31:0] req_period,
   input  wire logic [3:0]  req_slot,
   input  wire logic [31:0] req_runtime,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_released_task,
   output logic             rsp_released,
   output logic             rsp_last_result,
   output logic             rsp_status,
   output logic [31:0]      rsp_worst_runtime,
   output logic [31:0]      rsp_activations,
   output logic [31:0]      rsp_overruns,
   output logic [4:0]       rsp_tasks_registered,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   // widths that follow from the table depth
   localparam int unsigned AW     = $clog2(MAX_TASKS > 1 ? MAX_TASKS : 2);
   localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int unsigned IDX_W  = ptre_pkg::IDX_W;
   localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int unsigned HITS_W = ptre_pkg::HITS_W;
   localparam int unsigned ENT_W  = $bits(ptre_pkg::ptre_entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_REG_ADD,
      ST_POLL_TEST,
      ST_POLL_CHK,
      ST_POLL_ADV,
      ST_POLL_RES,
      ST_POLL_SYNC,
      ST_POLL_WR,
      ST_REP_WORST,
      ST_REP_LIM,
      ST_REP_ACT,
      ST_REP_OVR,
      ST_REP_WR,
      ST_QUERY,
      ST_OUT
   } state_type;

   // sequencer state
   state_type state_ff, state_in;
   state_type ret_ff,   ret_in;

   // latched request
   ptre_pkg::ptre_action_type act_ff, act_in;
   logic [31:0]      now_ff,    now_in;
   logic [31:0]      period_ff, period_in;
   logic [IDX_W-1:0] idx_ff,    idx_in;
   logic [31:0]      dur_ff,    dur_in;

   // global state
   logic [31:0]      limit_ff,   limit_in;
   logic [CNT_W-1:0] count_ff,   count_in;
   logic [31:0]      overrun_ff, overrun_in;

   // scan and working registers
   logic [CNT_W-1:0]  scan_ff,  scan_in;
   logic [HITS_W-1:0] hits_ff,  hits_in;
   logic [31:0]       due_ff,   due_in;
   logic [31:0]       worst_ff, worst_in;
   logic [31:0]       acts_ff,  acts_in;
   logic              ovr_hit_ff, ovr_hit_in;

   // release held back until we know whether it is the last one
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_slot_ff,  pend_slot_in;
   logic [31:0]       pend_worst_ff, pend_worst_in;
   logic [31:0]       pend_acts_ff,  pend_acts_in;

   // result staged for the output register
   logic [IDX_W-1:0]  res_slot_ff,     res_slot_in;
   logic              res_released_ff, res_released_in;
   logic              res_last_ff,     res_last_in;
   logic              res_status_ff,   res_status_in;
   logic [31:0]       res_worst_ff,    res_worst_in;
   logic [31:0]       res_acts_ff,     res_acts_in;

   // output register
   logic                                 rsp_valid_ff,    rsp_valid_in;
   logic [IDX_W-1:0]                     rsp_slot_ff,     rsp_slot_in;
   logic                                 rsp_released_ff, rsp_released_in;
   logic                                 rsp_last_ff,     rsp_last_in;
   logic                                 rsp_status_ff,   rsp_status_in;
   logic [31:0]                          rsp_worst_ff,    rsp_worst_in;
   logic [31:0]                          rsp_acts_ff,     rsp_acts_in;
   logic [31:0]                          rsp_ovr_ff,      rsp_ovr_in;
   logic [ptre_pkg::COUNT_OUT_W-1:0]     rsp_count_ff,    rsp_count_in;

   // table ram
   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   ptre_pkg::ptre_entry_type ram_wr_entry;
   logic                     ram_rd_en;
   logic [AW-1:0]            ram_rd_addr;
   logic [ENT_W-1:0]         ram_rd_data;
   ptre_pkg::ptre_entry_type rd_entry;

   // shared adder
   ptre_pkg::ptre_alu_op_type  alu_op;
   logic [31:0]                alu_a;
   logic [31:0]                alu_b;
   ptre_pkg::ptre_alu_res_type alu_res;

   // misc
   logic             out_free;
   logic             idx_ok;
   logic             table_full;
   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] scan_ext;

   ptre_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptre_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   assign rd_entry   = ram_rd_data;
   assign idx_ext    = CMP_W'(idx_ff);
   assign count_ext  = CMP_W'(count_ff);
   assign scan_ext   = CMP_W'(scan_ff);
   // index below the task count is also below the table depth
   assign idx_ok     = (idx_ext < count_ext);
   assign table_full = (count_ff == CNT_W'(MAX_TASKS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);

   // operand select for the shared adder
   always_comb begin
      alu_op = ptre_pkg::ALU_ADD;
      alu_a  = 32'd0;
      alu_b  = 32'd0;
      unique case (state_ff)
         ST_REG_ADD: begin
            alu_a = now_ff;
            alu_b = period_ff;
         end
         ST_POLL_CHK: begin
            // wrap-safe due test: now - due read as signed
            alu_op = ptre_pkg::ALU_SUB;
            alu_a  = now_ff;
            alu_b  = rd_entry.due;
         end
         ST_POLL_ADV: begin
            alu_a = rd_entry.due;
            alu_b = rd_entry.period;
         end
         ST_POLL_RES: begin
            alu_op = ptre_pkg::ALU_SUB;
            alu_a  = now_ff;
            alu_b  = due_ff;
         end
         ST_POLL_SYNC: begin
            alu_a = now_ff;
            alu_b = rd_entry.period;
         end
         ST_REP_WORST: begin
            alu_op = ptre_pkg::ALU_SUB;
            alu_a  = rd_entry.worst;
            alu_b  = dur_ff;
         end
         ST_REP_LIM: begin
            alu_op = ptre_pkg::ALU_SUB;
            alu_a  = limit_ff;
            alu_b  = dur_ff;
         end
         ST_REP_ACT: begin
            alu_a = rd_entry.acts;
            alu_b = 32'd1;
         end
         ST_REP_OVR: begin
            alu_a = overrun_ff;
            alu_b = 32'd1;
         end
         default: begin
            alu_op = ptre_pkg::ALU_ADD;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      act_in        = act_ff;
      now_in        = now_ff;
      period_in     = period_ff;
      idx_in        = idx_ff;
      dur_in        = dur_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      count_in      = count_ff;
      overrun_in    = overrun_ff;
      scan_in       = scan_ff;
      hits_in       = hits_ff;
      due_in        = due_ff;
      worst_in      = worst_ff;
      acts_in       = acts_ff;
      ovr_hit_in    = ovr_hit_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_worst_in = pend_worst_ff;
      pend_acts_in  = pend_acts_ff;

      res_slot_in     = res_slot_ff;
      res_released_in = res_released_ff;
      res_last_in     = res_last_ff;
      res_status_in   = res_status_ff;
      res_worst_in    = res_worst_ff;
      res_acts_in     = res_acts_ff;

      // result leaves the output register when taken
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_slot_in     = rsp_slot_ff;
      rsp_released_in = rsp_released_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_worst_in    = rsp_worst_ff;
      rsp_acts_in     = rsp_acts_ff;
      rsp_ovr_in      = rsp_ovr_ff;
      rsp_count_in    = rsp_count_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = scan_ff[AW-1:0];
      ram_wr_entry = rd_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in    = ptre_pkg::ptre_action_type'(req_action);
               now_in    = req_now_ms;
               period_in = req_period;
               idx_in    = req_slot;
               dur_in    = req_runtime;
               state_in  = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            unique case (act_ff)
               ptre_pkg::ACT_REGISTER: begin
                  if (table_full || period_ff == 32'd0) begin
                     res_slot_in     = '0;
                     res_released_in = 1'b0;
                     res_last_in     = 1'b1;
                     res_status_in   = 1'b1;
                     res_worst_in    = 32'd0;
                     res_acts_in     = 32'd0;
                     ret_in          = ST_IDLE;
                     state_in        = ST_OUT;
                  end else begin
                     state_in = ST_REG_ADD;
                  end
               end
               ptre_pkg::ACT_POLL: begin
                  scan_in       = '0;
                  hits_in       = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_POLL_TEST;
               end
               ptre_pkg::ACT_REPORT,
               ptre_pkg::ACT_QUERY: begin
                  if (!idx_ok) begin
                     res_slot_in     = idx_ff;
                     res_released_in = 1'b0;
                     res_last_in     = 1'b1;
                     res_status_in   = 1'b1;
                     res_worst_in    = 32'd0;
                     res_acts_in     = 32'd0;
                     ret_in          = ST_IDLE;
                     state_in        = ST_OUT;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = idx_ext[AW-1:0];
                     state_in    = (act_ff == ptre_pkg::ACT_REPORT) ? ST_REP_WORST
                                                                    : ST_QUERY;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_REG_ADD: begin
            // new slot gets due = now + period and cleared statistics
            ram_wr_en           = 1'b1;
            ram_wr_addr         = count_ff[AW-1:0];
            ram_wr_entry.period = period_ff;
            ram_wr_entry.due    = alu_res.value;
            ram_wr_entry.worst  = 32'd0;
            ram_wr_entry.acts   = 32'd0;
            res_slot_in         = count_ext[IDX_W-1:0];
            res_released_in     = 1'b0;
            res_last_in         = 1'b1;
            res_status_in       = 1'b0;
            res_worst_in        = 32'd0;
            res_acts_in         = 32'd0;
            count_in            = count_ff + CNT_W'(1);
            ret_in              = ST_IDLE;
            state_in            = ST_OUT;
         end

         ST_POLL_TEST: begin
            if (scan_ff < count_ff && hits_ff < HITS_W'(ptre_pkg::RESULTS_LIMIT)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_ff[AW-1:0];
               state_in    = ST_POLL_CHK;
            end else begin
               // scan done: flush the held release as last, or report nothing due
               res_slot_in     = pend_valid_ff ? pend_slot_ff : '0;
               res_released_in = pend_valid_ff;
               res_last_in     = 1'b1;
               res_status_in   = 1'b0;
               res_worst_in    = pend_valid_ff ? pend_worst_ff : 32'd0;
               res_acts_in     = pend_valid_ff ? pend_acts_ff : 32'd0;
               pend_valid_in   = 1'b0;
               ret_in          = ST_IDLE;
               state_in        = ST_OUT;
            end
         end

         ST_POLL_CHK: begin
            if (alu_res.sign) begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_POLL_TEST;
            end else begin
               state_in = ST_POLL_ADV;
            end
         end

         ST_POLL_ADV: begin
            due_in   = alu_res.value;
            state_in = ST_POLL_RES;
         end

         ST_POLL_RES: begin
            // still strictly behind now: resynchronise
            state_in = (!alu_res.zero && !alu_res.sign) ? ST_POLL_SYNC : ST_POLL_WR;
         end

         ST_POLL_SYNC: begin
            due_in   = alu_res.value;
            state_in = ST_POLL_WR;
         end

         ST_POLL_WR: begin
            ram_wr_en        = 1'b1;
            ram_wr_addr      = scan_ff[AW-1:0];
            ram_wr_entry.due = due_ff;
            hits_in          = hits_ff + HITS_W'(1);
            scan_in          = scan_ff + CNT_W'(1);
            pend_valid_in    = 1'b1;
            pend_slot_in     = scan_ext[IDX_W-1:0];
            pend_worst_in    = rd_entry.worst;
            pend_acts_in     = rd_entry.acts;
            if (pend_valid_ff) begin
               // a later release exists, so the held one is not last
               res_slot_in     = pend_slot_ff;
               res_released_in = 1'b1;
               res_last_in     = 1'b0;
               res_status_in   = 1'b0;
               res_worst_in    = pend_worst_ff;
               res_acts_in     = pend_acts_ff;
               ret_in          = ST_POLL_TEST;
               state_in        = ST_OUT;
            end else begin
               state_in = ST_POLL_TEST;
            end
         end

         ST_REP_WORST: begin
            worst_in = alu_res.borrow ? dur_ff : rd_entry.worst;
            state_in = ST_REP_LIM;
         end

         ST_REP_LIM: begin
            ovr_hit_in = alu_res.borrow;
            state_in   = ST_REP_ACT;
         end

         ST_REP_ACT: begin
            acts_in  = alu_res.value;
            state_in = ovr_hit_ff ? ST_REP_OVR : ST_REP_WR;
         end

         ST_REP_OVR: begin
            overrun_in = alu_res.value;
            state_in   = ST_REP_WR;
         end

         ST_REP_WR: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = idx_ext[AW-1:0];
            ram_wr_entry.worst = worst_ff;
            ram_wr_entry.acts  = acts_ff;
            res_slot_in        = idx_ff;
            res_released_in    = 1'b0;
            res_last_in        = 1'b1;
            res_status_in      = 1'b0;
            res_worst_in       = worst_ff;
            res_acts_in        = acts_ff;
            ret_in             = ST_IDLE;
            state_in           = ST_OUT;
         end

         ST_QUERY: begin
            res_slot_in     = idx_ff;
            res_released_in = 1'b0;
            res_last_in     = 1'b1;
            res_status_in   = 1'b0;
            res_worst_in    = rd_entry.worst;
            res_acts_in     = rd_entry.acts;
            ret_in          = ST_IDLE;
            state_in        = ST_OUT;
         end

         ST_OUT: begin
            // wait for room in the output register
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_slot_in     = res_slot_ff;
               rsp_released_in = res_released_ff;
               rsp_last_in     = res_last_ff;
               rsp_status_in   = res_status_ff;
               rsp_worst_in    = res_worst_ff;
               rsp_acts_in     = res_acts_ff;
               rsp_ovr_in      = overrun_ff;
               rsp_count_in    = ptre_pkg::COUNT_OUT_W'(count_ff);
               state_in        = ret_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         limit_ff      <= ptre_pkg::LIMIT_RESET;
         count_ff      <= '0;
         overrun_ff    <= 32'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         limit_ff      <= limit_in;
         count_ff      <= count_in;
         overrun_ff    <= overrun_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      act_ff          <= act_in;
      now_ff          <= now_in;
      period_ff       <= period_in;
      idx_ff          <= idx_in;
      dur_ff          <= dur_in;
      scan_ff         <= scan_in;
      hits_ff         <= hits_in;
      due_ff          <= due_in;
      worst_ff        <= worst_in;
      acts_ff         <= acts_in;
      ovr_hit_ff      <= ovr_hit_in;
      pend_slot_ff    <= pend_slot_in;
      pend_worst_ff   <= pend_worst_in;
      pend_acts_ff    <= pend_acts_in;
      res_slot_ff     <= res_slot_in;
      res_released_ff <= res_released_in;
      res_last_ff     <= res_last_in;
      res_status_ff   <= res_status_in;
      res_worst_ff    <= res_worst_in;
      res_acts_ff     <= res_acts_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_released_ff <= rsp_released_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_worst_ff    <= rsp_worst_in;
      rsp_acts_ff     <= rsp_acts_in;
      rsp_ovr_ff      <= rsp_ovr_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_released_task     = rsp_slot_ff;
   assign rsp_released          = rsp_released_ff;
   assign rsp_last_result       = rsp_last_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_worst_runtime     = rsp_worst_ff;
   assign rsp_activations       = rsp_acts_ff;
   assign rsp_overruns          = rsp_ovr_ff;
   assign rsp_tasks_registered  = rsp_count_ff;

endmodule

`default_nettype wire

### rtl/core/ptre_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ptre_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/ptre_alu.sv
// shared 32-bit add / subtract unit with compare flags
`timescale 1ns / 1ps
`default_nettype none

module ptre_alu (
   input  wire ptre_pkg::ptre_alu_op_type  op,
   input  wire logic [31:0]                a,
   input  wire logic [31:0]                b,
   output ptre_pkg::ptre_alu_res_type      res
);

   logic [32:0] sum;

   always_comb begin
      unique case (op)
         ptre_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
         ptre_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
         default:           sum = '0;
      endcase
      res.value  = sum[31:0];
      // borrow only means a < b on a subtract
      res.borrow = sum[32];
      res.zero   = (sum[31:0] == 32'd0);
      res.sign   = sum[31];
   end

endmodule

`default_nettype wire

### rtl/core/ptre_checker.sv
// port-level checker for the periodic task release engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ptre_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_released_task,
   input wire logic        rsp_released,
   input wire logic        rsp_last_result,
   input wire logic        rsp_status,
   input wire logic [31:0] rsp_worst_runtime,
   input wire logic [31:0] rsp_overruns
);

   // reset leaves no result in the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_released_task)
         && $stable(rsp_released) && $stable(rsp_last_result)
         && $stable(rsp_worst_runtime) && $stable(rsp_overruns))
      else $error("stalled result changed");

   // one request at a time: busy right after acceptance
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a release is never a rejection
   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_released |-> !rsp_status)
      else $error("release result with error status");

   // only poll releases can be followed by more results
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_released |-> rsp_last_result)
      else $error("non-release result not marked last");

endmodule

bind periodic_task_release_engine_core ptre_checker u_ptre_checker (.*);

`default_nettype wire

### verif/tb_periodic_task_release_engine_core.sv
// testbench of the periodic task release engine core: directed table, then random requests checked against a predictor
`timescale 1ns / 1ps
module tb_periodic_task_release_engine_core;

   localparam int unsigned TASK_SLOTS       = 16;
   localparam int unsigned GAP_MAX          = 16;
   localparam int unsigned RESET_CYCLES     = 12;
   // a poll with sixteen releases and a slow receiver stays far below this
   localparam int unsigned WATCHDOG_LIMIT   = 5000;
   localparam int unsigned HOLD_CYCLES      = 300;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned TAIL_CYCLES      = 150;
   localparam int unsigned PHASES           = 5;
   localparam int unsigned RANDOM_PER_PHASE = 72;

   // one request as it crosses the req channel
   typedef struct packed {
      ptre_pkg::ptre_action_type action;
      logic [31:0]               now_ms;
      logic [31:0]               period;
      logic [3:0]                slot;
      logic [31:0]               runtime;
   } sched_req_type;

   // one result as it crosses the rsp channel
   typedef struct packed {
      logic [3:0]  released_task;
      logic        released;
      logic        last_result;
      logic        status;
      logic [31:0] worst_runtime;
      logic [31:0] activations;
      logic [31:0] overruns;
      logic [4:0]  tasks_registered;
   } sched_rsp_type;

   // directed table row: request plus an optional typed-in result
   typedef struct packed {
      sched_req_type req;
      logic          fixed_expect;
      sched_rsp_type rsp;
   } stim_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action  = '0;
   logic [31:0] req_now_ms  = '0;
   logic [31:0] req_period  = '0;
   logic [3:0]  req_slot    = '0;
   logic [31:0] req_runtime = '0;

   // result channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_released_task;
   logic        rsp_released;
   logic        rsp_last_result;
   logic        rsp_status;
   logic [31:0] rsp_worst_runtime;
   logic [31:0] rsp_activations;
   logic [31:0] rsp_overruns;
   logic [4:0]  rsp_tasks_registered;

   // overrun limit register
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // typed-in result travels with its request, updated on the same edge
   logic          row_fixed  = 1'b0;
   sched_rsp_type row_expect = '0;

   // predictor copy of the task table and counters
   logic [31:0] slot_period [TASK_SLOTS];
   logic [31:0] slot_due    [TASK_SLOTS];
   logic [31:0] slot_worst  [TASK_SLOTS];
   logic [31:0] slot_acts   [TASK_SLOTS];
   logic [4:0]  slot_count    = '0;
   logic [31:0] overrun_count = '0;
   logic [31:0] limit_ms      = ptre_pkg::LIMIT_RESET;

   // results still owed by the block, oldest first
   sched_rsp_type release_results [$];

   int unsigned mismatches   = 0;
   int unsigned quiet_cycles = 0;

   // idling knobs shared by the two sides
   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   bit hold_request  = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   periodic_task_release_engine_core #(
      .MAX_TASKS(TASK_SLOTS)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_now_ms            (req_now_ms),
      .req_period            (req_period),
      .req_slot              (req_slot),
      .req_runtime           (req_runtime),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_released_task     (rsp_released_task),
      .rsp_released          (rsp_released),
      .rsp_last_result       (rsp_last_result),
      .rsp_status            (rsp_status),
      .rsp_worst_runtime     (rsp_worst_runtime),
      .rsp_activations       (rsp_activations),
      .rsp_overruns          (rsp_overruns),
      .rsp_tasks_registered  (rsp_tasks_registered),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   function automatic sched_req_type mk_req(input ptre_pkg::ptre_action_type action,
                                            input logic [31:0] now_ms,
                                            input logic [31:0] period,
                                            input logic [3:0] slot,
                                            input logic [31:0] runtime);
      sched_req_type r;
      r.action  = action;
      r.now_ms  = now_ms;
      r.period  = period;
      r.slot    = slot;
      r.runtime = runtime;
      return r;
   endfunction

   function automatic sched_rsp_type mk_rsp(input logic [3:0] released_task,
                                            input logic released, input logic last_result,
                                            input logic status, input logic [31:0] worst,
                                            input logic [31:0] acts,
                                            input logic [31:0] overruns,
                                            input logic [4:0] tasks_registered);
      sched_rsp_type r;
      r.released_task    = released_task;
      r.released         = released;
      r.last_result      = last_result;
      r.status           = status;
      r.worst_runtime    = worst;
      r.activations      = acts;
      r.overruns         = overruns;
      r.tasks_registered = tasks_registered;
      return r;
   endfunction

   function automatic stim_row_type mk_row(input sched_req_type req,
                                           input logic fixed_expect,
                                           input sched_rsp_type rsp);
      stim_row_type row;
      row.req          = req;
      row.fixed_expect = fixed_expect;
      row.rsp          = rsp;
      return row;
   endfunction

   // scheduler step: updates the table copy and queues every result of one request
   task automatic schedule_step(input sched_req_type r);
      sched_rsp_type res;
      sched_rsp_type hits [$];
      logic [31:0] lag;
      int i;
      res = '0;
      res.last_result = 1'b1;
      if (r.action == ptre_pkg::ACT_POLL) begin
         for (i = 0; i < slot_count; i++) begin
            if (hits.size() >= ptre_pkg::RESULTS_LIMIT) break;
            // wrap-safe due test: now minus due read as signed is not negative
            lag = r.now_ms - slot_due[i];
            if (!lag[31]) begin
               slot_due[i] = slot_due[i] + slot_period[i];
               lag = r.now_ms - slot_due[i];
               // still behind after one period: resync to now plus period
               if (lag != 0 && !lag[31]) slot_due[i] = r.now_ms + slot_period[i];
               res = '0;
               res.released_task    = i[3:0];
               res.released         = 1'b1;
               res.worst_runtime    = slot_worst[i];
               res.activations      = slot_acts[i];
               res.overruns         = overrun_count;
               res.tasks_registered = slot_count;
               hits.push_back(res);
            end
         end
         if (hits.size() == 0) begin
            // nothing due: one idle result
            res.overruns         = overrun_count;
            res.tasks_registered = slot_count;
            release_results.push_back(res);
         end else begin
            foreach (hits[k]) begin
               res = hits[k];
               res.last_result = (k == hits.size() - 1);
               release_results.push_back(res);
            end
         end
      end else begin
         case (r.action)
            ptre_pkg::ACT_REGISTER: begin
               if (slot_count >= TASK_SLOTS || r.period == 0) begin
                  // table full or zero period
                  res.status = 1'b1;
               end else begin
                  res.released_task       = slot_count[3:0];
                  slot_period[slot_count] = r.period;
                  slot_worst[slot_count]  = '0;
                  slot_acts[slot_count]   = '0;
                  slot_due[slot_count]    = r.now_ms + r.period;
                  slot_count              = slot_count + 5'd1;
               end
            end
            default: begin
               res.released_task = r.slot;
               if (r.slot >= slot_count) begin
                  // index at or beyond the task count
                  res.status = 1'b1;
               end else begin
                  if (r.action == ptre_pkg::ACT_REPORT) begin
                     if (r.runtime > slot_worst[r.slot])
                        slot_worst[r.slot] = r.runtime;
                     if (r.runtime > limit_ms) overrun_count = overrun_count + 32'd1;
                     slot_acts[r.slot] = slot_acts[r.slot] + 32'd1;
                  end
                  res.worst_runtime = slot_worst[r.slot];
                  res.activations   = slot_acts[r.slot];
               end
            end
         endcase
         res.overruns         = overrun_count;
         res.tasks_registered = slot_count;
         release_results.push_back(res);
      end
   endtask

   task automatic check_field(input string fname, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, fname, exp_v, act_v);
      end
   endtask

   // offer one request after a random gap and return at the edge that takes it;
   // valid stays high so a back-to-back request needs no second assignment
   task automatic send_request(input sched_req_type r, input logic fixed_expect,
                               input sched_rsp_type fixed_rsp);
      int gap;
      gap = sender_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= r.action;
      req_now_ms  <= r.now_ms;
      req_period  <= r.period;
      req_slot    <= r.slot;
      req_runtime <= r.runtime;
      row_fixed   <= fixed_expect;
      row_expect  <= fixed_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering, wait for every owed result, then let the block settle
   task automatic wait_drained(input int unsigned settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (release_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // overrun limit write, only while the block is idle
   task automatic write_limit(input logic [31:0] value);
      wait_drained(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_ms = value;
   endtask

   // monitor: check taken results, predict on taken requests
   always @(posedge clock) begin : monitor
      sched_req_type taken;
      sched_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (release_results.size() == 0) begin
               mismatches++;
               $display("%0t: result expected none actual task %h", $time,
                        rsp_released_task);
            end else begin
               want = release_results.pop_front();
               check_field("released_task", 32'(want.released_task),
                           32'(rsp_released_task));
               check_field("released", 32'(want.released), 32'(rsp_released));
               check_field("last_result", 32'(want.last_result), 32'(rsp_last_result));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("worst_runtime", want.worst_runtime, rsp_worst_runtime);
               check_field("activations", want.activations, rsp_activations);
               check_field("overruns", want.overruns, rsp_overruns);
               check_field("tasks_registered", 32'(want.tasks_registered),
                           32'(rsp_tasks_registered));
            end
         end
         if (req_valid && !req_stall) begin
            taken.action  = ptre_pkg::ptre_action_type'(req_action);
            taken.now_ms  = req_now_ms;
            taken.period  = req_period;
            taken.slot    = req_slot;
            taken.runtime = req_runtime;
            schedule_step(taken);
            // typed-in rows replace the single predicted result
            if (row_fixed) begin
               void'(release_results.pop_back());
               release_results.push_back(row_expect);
            end
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_periodic_task_release_engine_core failed");
            $finish;
         end
      end
   end

   // receiver: random stall per result, plus one long hold on request
   initial begin : result_sink
      int hold;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         hold = receiver_idle ? $urandom_range(0, GAP_MAX) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // sender: directed table, then phases of random requests
   initial begin : stimulus
      stim_row_type rows [$];
      sched_req_type item;
      logic [31:0] tick;
      logic [31:0] phase_limit;
      int pick;
      int ph;
      int n;

      foreach (slot_period[s]) begin
         slot_period[s] = '0;
         slot_due[s]    = '0;
         slot_worst[s]  = '0;
         slot_acts[s]   = '0;
      end

      // empty table: query, report past the count, idle poll
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_QUERY, 0, 0, 4'd0, 0), 1'b1,
                            mk_rsp(4'd0, 1'b0, 1'b1, 1'b1, 0, 0, 0, 5'd0)));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REPORT, 0, 0, 4'd15, 32'hFFFF_FFFF), 1'b1,
                            mk_rsp(4'd15, 1'b0, 1'b1, 1'b1, 0, 0, 0, 5'd0)));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_POLL, 0, 0, 4'd0, 0), 1'b1,
                            mk_rsp(4'd0, 1'b0, 1'b1, 1'b0, 0, 0, 0, 5'd0)));
      // zero period is rejected
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REGISTER, 32'd5, 0, 4'd0, 0), 1'b1,
                            mk_rsp(4'd0, 1'b0, 1'b1, 1'b1, 0, 0, 0, 5'd0)));
      // smallest and largest period, due time wrapping
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REGISTER, 0, 32'd1, 4'd0, 0), 1'b1,
                            mk_rsp(4'd0, 1'b0, 1'b1, 1'b0, 0, 0, 0, 5'd1)));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   4'd0, 0),
                            1'b1, mk_rsp(4'd1, 1'b0, 1'b1, 1'b0, 0, 0, 0, 5'd2)));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REGISTER, 32'd100, 32'd50, 4'd0, 0), 1'b1,
                            mk_rsp(4'd2, 1'b0, 1'b1, 1'b0, 0, 0, 0, 5'd3)));
      // polls around the signed wrap boundary
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_POLL, 0, 0, 4'd0, 0), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_POLL, 32'd1, 0, 4'd0, 0), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_POLL, 32'h8000_0000, 0, 4'd0, 0), 1'b0,
                            '0));
      // durations at and just above the limit, largest duration
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REPORT, 0, 0, 4'd0, 32'd10), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REPORT, 0, 0, 4'd0, 32'd11), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REPORT, 0, 0, 4'd1, 32'hFFFF_FFFF), 1'b0,
                            '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REPORT, 0, 0, 4'd2, 32'd0), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_QUERY, 0, 0, 4'd0, 0), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_QUERY, 0, 0, 4'd2, 0), 1'b0, '0));
      // index equal to the count, largest index
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REPORT, 0, 0, 4'd3, 32'd20), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_QUERY, 0, 0, 4'd15, 0), 1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_POLL, 32'hFFFF_FFFF, 0, 4'd0, 0), 1'b0,
                            '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_REGISTER, 32'h7FFF_FFFF, 32'h8000_0000,
                                   4'd0, 0),
                            1'b0, '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_POLL, 32'h7FFF_FFFF, 0, 4'd0, 0), 1'b0,
                            '0));
      rows.push_back(mk_row(mk_req(ptre_pkg::ACT_POLL, 32'hFFFF_FFFF, 0, 4'd0, 0), 1'b0,
                            '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         send_request(rows[r].req, rows[r].fixed_expect, rows[r].rsp);
      end

      tick = $urandom_range(0, 1000);
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: phase_limit = 32'd0;
            1: phase_limit = 32'hFFFF_FFFF;
            2: phase_limit = $urandom_range(1, 40);
            3: phase_limit = 32'h8000_0000;
            default: phase_limit = 32'd5;
         endcase
         write_limit(phase_limit);
         // last phase runs without any idling
         sender_idle   = (ph != PHASES - 1);
         receiver_idle = (ph != PHASES - 1);
         // cross the 32-bit wrap of the tick
         if (ph == 3) tick = 32'hFFFF_FF00;

         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // long receiver hold while requests keep coming back to back
            if (ph == 1 && n == 10) begin
               hold_request = 1'b1;
               sender_idle  = 1'b0;
            end
            if (ph == 1 && n == 40) sender_idle = 1'b1;
            // sender pause until every owed result is in
            if (ph == 2 && n == 38) wait_drained(SETTLE_CYCLES);

            item = '0;
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               // noise: every field random
               item.action  = ptre_pkg::ptre_action_type'(2'($urandom_range(0, 3)));
               item.now_ms  = $urandom;
               item.period  = $urandom;
               item.slot    = 4'($urandom_range(0, 15));
               item.runtime = $urandom;
            end else if (pick < 35) begin
               item.action = ptre_pkg::ACT_REGISTER;
               item.now_ms = tick;
               case ($urandom_range(0, 15))
                  0:       item.period = '0;
                  1, 2:    item.period = $urandom;
                  default: item.period = $urandom_range(1, 40);
               endcase
            end else if (pick < 65) begin
               // tick mostly creeps, sometimes jumps far enough to force resync
               item.action = ptre_pkg::ACT_POLL;
               if ($urandom_range(0, 9) == 0) tick = tick + $urandom_range(100, 5000);
               else tick = tick + $urandom_range(0, 25);
               item.now_ms = tick;
            end else begin
               item.action = (pick < 88) ? ptre_pkg::ACT_REPORT : ptre_pkg::ACT_QUERY;
               if (slot_count != 0 && $urandom_range(0, 7) != 0)
                  item.slot = 4'($urandom_range(0, slot_count - 1));
               else
                  item.slot = 4'($urandom_range(0, 15));
               case ($urandom_range(0, 4))
                  0:       item.runtime = limit_ms - 32'd1;
                  1:       item.runtime = limit_ms;
                  2:       item.runtime = limit_ms + 32'd1;
                  3:       item.runtime = $urandom_range(0, 40);
                  default: item.runtime = $urandom;
               endcase
            end
            send_request(item, 1'b0, '0);
         end
      end

      wait_drained(TAIL_CYCLES);
      if (mismatches == 0) begin
         $display("tb_periodic_task_release_engine_core passed");
      end else begin
         $display("tb_periodic_task_release_engine_core failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/ptre_pkg.sv
rtl/core/ptre_ram.sv
rtl/core/ptre_alu.sv
rtl/core/periodic_task_release_engine_core.sv
rtl/core/ptre_checker.sv
verif/tb_periodic_task_release_engine_core.sv
